/* sv/learning_bridge_mac_table_defines.svh */
// Assertion macros shared by the learning bridge address table RTL.
`ifndef LEARNING_BRIDGE_MAC_TABLE_DEFINES_SVH
`define LEARNING_BRIDGE_MAC_TABLE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LBMT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LBMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lbmt_pkg.sv */
// Package with the table geometry, shared types, codes and the hash function.
`default_nettype none

package lbmt_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 8192;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int ADDR_W        = 48;
  localparam int PORT_W        = 4;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [ADDR_W-1:0] mac_t;
  typedef logic [PORT_W-1:0] port_t;

  // Learn status codes.
  localparam logic [1:0] LS_UPDATED     = 2'd0;
  localparam logic [1:0] LS_INSERTED    = 2'd1;
  localparam logic [1:0] LS_FULL        = 2'd2;
  localparam logic [1:0] LS_NOT_LEARNED = 2'd3;

  // Operating modes.
  localparam logic MODE_FRAME  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // One table slot as stored in memory.
  typedef struct packed {
    logic  valid;
    mac_t  addr;
    port_t port;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic start_dst;
    logic start_src;
    logic probe_next;
    logic dst_hit;
    logic src_upd;
    logic src_ins;
    logic src_full;
    logic clr_wr;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic dst_group;
    logic src_group;
    logic hit;
    logic empty;
    logic last;
    logic clr_last;
  } sts_t;

  // Home slot: XOR of the three byte-swapped 16-bit words, masked to the table.
  function automatic slot_t home_slot(input mac_t a);
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] h;
    w0 = {a[39:32], a[47:40]};
    w1 = {a[23:16], a[31:24]};
    w2 = {a[7:0],   a[15:8]};
    h  = w0 ^ w1 ^ w2;
    return h[SLOT_W-1:0];
  endfunction

  // Group addresses have bit 0 of the first byte set.
  function automatic logic is_group(input mac_t a);
    return a[40];
  endfunction

endpackage

`default_nettype wire

/* sv/lbmt_datapath.sv */
// Datapath: item registers, probe slot and counter, table memory and results.
`default_nettype none

module lbmt_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lbmt_pkg::cmd_t   cmd_i,
  output lbmt_pkg::sts_t        sts_o,
  input  wire logic             mode_i,
  input  wire lbmt_pkg::port_t  in_port_i,
  input  wire lbmt_pkg::mac_t   dest_addr_i,
  input  wire lbmt_pkg::mac_t   src_addr_i,
  output logic                  forward_o,
  output logic                  found_o,
  output lbmt_pkg::port_t       port_out_o,
  output logic [1:0]            learn_status_o
);

  // Captured item.
  logic            mode_q;
  lbmt_pkg::port_t port_q;
  lbmt_pkg::mac_t  dst_q;
  lbmt_pkg::mac_t  src_q;

  // Probe state.
  lbmt_pkg::slot_t slot_q, slot_d;
  lbmt_pkg::slot_t cnt_q, cnt_d;
  logic            key_src_q;
  lbmt_pkg::mac_t  key;

  // Clearing sweep counter.
  lbmt_pkg::slot_t clr_q;

  // Table memory and its registered read data.
  lbmt_pkg::entry_t mem_q [lbmt_pkg::TABLE_ENTRIES];
  lbmt_pkg::entry_t rd_q;
  lbmt_pkg::slot_t  mem_addr;
  lbmt_pkg::entry_t wr_data;
  logic             mem_we;

  // Working result and the output register.
  logic            res_fwd_q;
  logic            res_found_q;
  lbmt_pkg::port_t res_port_q;
  logic [1:0]      res_status_q;

  // Capture the item on its input transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= mode_i;
      port_q <= in_port_i;
      dst_q  <= dest_addr_i;
      src_q  <= src_addr_i;
    end
  end

  // Slot and visit count of the running probe.
  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (cmd_i.start_dst) begin
      slot_d = lbmt_pkg::home_slot(dst_q);
      cnt_d  = '0;
    end else if (cmd_i.start_src) begin
      slot_d = lbmt_pkg::home_slot(src_q);
      cnt_d  = '0;
    end else if (cmd_i.probe_next) begin
      slot_d = slot_q + 1'b1;
      cnt_d  = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    cnt_q  <= cnt_d;
    if (cmd_i.start_dst) begin
      key_src_q <= 1'b0;
    end else if (cmd_i.start_src) begin
      key_src_q <= 1'b1;
    end
  end

  // The sweep counter starts at slot zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Memory port: the sweep owns it while clearing, the probe otherwise.
  assign mem_addr = cmd_i.clr_wr ? clr_q : slot_q;
  assign mem_we   = cmd_i.clr_wr | cmd_i.src_upd | cmd_i.src_ins;
  always_comb begin
    wr_data = '0;
    if (!cmd_i.clr_wr) begin
      wr_data.valid = 1'b1;
      wr_data.addr  = src_q;
      wr_data.port  = port_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= wr_data;
    end
    rd_q <= mem_q[mem_addr];
  end

  // Compare the slot just read against the probed key.
  assign key = key_src_q ? src_q : dst_q;
  always_comb begin
    sts_o           = '0;
    sts_o.mode      = mode_q;
    sts_o.dst_group = lbmt_pkg::is_group(dst_q);
    sts_o.src_group = lbmt_pkg::is_group(src_q);
    sts_o.hit       = rd_q.valid && (rd_q.addr == key);
    sts_o.empty     = !rd_q.valid;
    sts_o.last      = (cnt_q == lbmt_pkg::slot_t'(lbmt_pkg::TABLE_ENTRIES - 1));
    sts_o.clr_last  = (clr_q == lbmt_pkg::slot_t'(lbmt_pkg::TABLE_ENTRIES - 1));
  end

  // Build the result while the item is worked on.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      res_fwd_q    <= 1'b1;
      res_found_q  <= 1'b0;
      res_port_q   <= '0;
      res_status_q <= lbmt_pkg::LS_NOT_LEARNED;
    end else begin
      if (cmd_i.dst_hit) begin
        res_found_q <= 1'b1;
        res_port_q  <= rd_q.port;
        res_fwd_q   <= (mode_q == lbmt_pkg::MODE_LOOKUP) || (rd_q.port != port_q);
      end
      if (cmd_i.src_upd) begin
        res_status_q <= lbmt_pkg::LS_UPDATED;
      end else if (cmd_i.src_ins) begin
        res_status_q <= lbmt_pkg::LS_INSERTED;
      end else if (cmd_i.src_full) begin
        res_status_q <= lbmt_pkg::LS_FULL;
      end
    end
  end

  // Output register holds a finished result until its transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      forward_o      <= res_fwd_q;
      found_o        <= res_found_q;
      port_out_o     <= res_port_q;
      learn_status_o <= res_status_q;
    end
  end

endmodule

`default_nettype wire

/* sv/lbmt_ctrl.sv */
// Controller: clearing sweep, probe sequencing and the handshakes.
`default_nettype none

module lbmt_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire lbmt_pkg::sts_t  sts_i,
  output lbmt_pkg::cmd_t       cmd_o
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_START_D = 4'd2;
  localparam logic [3:0] S_RD_D    = 4'd3;
  localparam logic [3:0] S_CK_D    = 4'd4;
  localparam logic [3:0] S_START_S = 4'd5;
  localparam logic [3:0] S_RD_S    = 4'd6;
  localparam logic [3:0] S_CK_S    = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_START_D;
        end
      end
      S_START_D: begin
        if ((sts_i.mode == lbmt_pkg::MODE_FRAME) && sts_i.dst_group) begin
          state_d = S_START_S;
        end else begin
          cmd_o.start_dst = 1'b1;
          state_d         = S_RD_D;
        end
      end
      S_RD_D: begin
        state_d = S_CK_D;
      end
      S_CK_D: begin
        if (sts_i.hit || sts_i.empty || sts_i.last) begin
          cmd_o.dst_hit = sts_i.hit;
          state_d       = (sts_i.mode == lbmt_pkg::MODE_LOOKUP) ? S_DONE : S_START_S;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d          = S_RD_D;
        end
      end
      S_START_S: begin
        if (sts_i.src_group) begin
          state_d = S_DONE;
        end else begin
          cmd_o.start_src = 1'b1;
          state_d         = S_RD_S;
        end
      end
      S_RD_S: begin
        state_d = S_CK_S;
      end
      S_CK_S: begin
        if (sts_i.hit) begin
          cmd_o.src_upd = 1'b1;
          state_d       = S_DONE;
        end else if (sts_i.empty) begin
          cmd_o.src_ins = 1'b1;
          state_d       = S_DONE;
        end else if (sts_i.last) begin
          cmd_o.src_full = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d          = S_RD_S;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output valid flag follows loads and output transfers.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* sv/learning_bridge_mac_table.sv */
// Learning bridge address table: open-addressed hash with linear probing.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item per transfer:
//   mode 0 filters and learns one frame, mode 1 looks up dest_addr_i.
//   Output channel (out_valid_o/out_ready_i) returns one result per item.
// Timing:
//   After reset the block sweeps all 8192 slots to clear their valid bits,
//   one slot a cycle, before in_ready_o first rises.
//   A frame probes for its destination and then for its source, each probe
//   skipped for a group address; each slot visited is one read of the
//   single table port plus one compare.
//   One item is worked on at a time; the next is accepted as soon as the
//   previous result has moved into the output register.
// Stalls:
//   A result waits in the output register until taken; a finished second
//   item waits inside the block until the register is free.
`default_nettype none

module learning_bridge_mac_table (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            mode_i,
  input  wire lbmt_pkg::port_t in_port_i,
  input  wire lbmt_pkg::mac_t  dest_addr_i,
  input  wire lbmt_pkg::mac_t  src_addr_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 forward_o,
  output logic                 found_o,
  output lbmt_pkg::port_t      port_out_o,
  output logic [1:0]           learn_status_o
);

  lbmt_pkg::cmd_t cmd;
  lbmt_pkg::sts_t sts;

  lbmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lbmt_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (mode_i),
    .in_port_i      (in_port_i),
    .dest_addr_i    (dest_addr_i),
    .src_addr_i     (src_addr_i),
    .forward_o      (forward_o),
    .found_o        (found_o),
    .port_out_o     (port_out_o),
    .learn_status_o (learn_status_o)
  );

  // Checks on the sequencing.
`include "learning_bridge_mac_table_defines.svh"

  `LBMT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "accepted item while busy")
  `LBMT_ASSERT_SAME(a_no_accept_in_clear, cmd.clr_wr, !in_ready_o, "input ready during clearing sweep")
  `LBMT_ASSERT_SAME(a_learn_frame_only, cmd.src_upd || cmd.src_ins, sts.mode == lbmt_pkg::MODE_FRAME, "table written in lookup mode")
  `LBMT_ASSERT_NEXT(a_load_shows_valid, cmd.out_load, out_valid_o, "loaded result not presented")

endmodule

`default_nettype wire
